/* rtl/assert_macros.svh */
// assertion macros shared by the deque rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must follow from antecedent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// shared types and constants for the double-ended queue
// no dependencies
package deq_pkg;

	localparam int DEPTH_DEFAULT      = 1024;
	localparam int DATA_WIDTH_DEFAULT = 32;

	localparam int MODE_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 11;
	localparam int DOUT_W   = 32;
	localparam int OCC_W    = 11;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd1;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_READ_AT    = 4'd4;
	localparam logic [MODE_W-1:0] MODE_WRITE_AT   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_DROP_FRONT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_DROP_BACK  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd8;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// control half of a command passed from front to back
	typedef struct packed {
		logic                we;
		logic                re;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} deq_ctl_t;

endpackage

/* rtl/deq_if.sv */
// request and response channel interfaces of the deque
// depends on deq_pkg for field widths
interface deq_req_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::MODE_W-1:0]          mode;
	logic signed [deq_pkg::VALUE_W-1:0]  value;
	logic [deq_pkg::INDEX_W-1:0]         index;

	modport source (output valid, output mode, output value, output index, input ready);
	modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface deq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [deq_pkg::DOUT_W-1:0]   data_out;
	logic [deq_pkg::OCC_W-1:0]           occupancy;
	logic [deq_pkg::STATUS_W-1:0]        status;

	modport source (output valid, output data_out, output occupancy, output status, input ready);
	modport sink   (input valid, input data_out, input occupancy, input status, output ready);
endinterface

/* rtl/double_ended_queue.sv */
// top level of the bounded double-ended queue
// depends on deq_pkg, deq_if, deq_front, deq_fifo, deq_back
//
// Bounded deque in a single-port circular store of DEPTH entries of DATA_WIDTH bits. Every
// request transaction (push or pop at either end, read or write at a distance from the front,
// drop from either end, clear) gives exactly one response transaction with the value read,
// the occupancy afterwards and a status (0 ok, 1 empty or out of range, 2 full). The front end
// updates head and count in the cycle a request is accepted, so requests are taken one per
// cycle while the two-entry command queue is not full; that queue decouples it from the back
// end, which does one memory access per cycle with a registered read and then loads the
// response register. While the output is not stalled, sustained throughput is one
// transaction per cycle, bounded by the single memory port.
// Stored entries need no clearing after reset; only written entries are ever read.

module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CMD_W = $bits(deq_pkg::deq_ctl_t) + AW + DATA_WIDTH;

	logic                    f_push, f_full, f_pop, f_nonempty;
	deq_pkg::deq_ctl_t       f_ctl, b_ctl;
	logic [AW-1:0]           f_addr, b_addr;
	logic [DATA_WIDTH-1:0]   f_wdata, b_wdata;
	logic [CMD_W-1:0]        q_in, q_out;

	deq_front #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_push  (f_push),
		.cmd_ctl   (f_ctl),
		.cmd_addr  (f_addr),
		.cmd_wdata (f_wdata),
		.cmd_full  (f_full)
	);

	assign q_in = {f_ctl, f_addr, f_wdata};
	assign {b_ctl, b_addr, b_wdata} = q_out;

	deq_fifo #(
		.WIDTH (CMD_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (q_in),
		.full      (f_full),
		.pop       (f_pop),
		.pop_data  (q_out),
		.nonempty  (f_nonempty)
	);

	deq_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (f_nonempty),
		.cmd_ctl   (b_ctl),
		.cmd_addr  (b_addr),
		.cmd_wdata (b_wdata),
		.cmd_pop   (f_pop),
		.rsp       (rsp)
	);

endmodule

/* rtl/deq_front.sv */
// front end: accepts requests, checks them against head and count, issues memory commands
// depends on deq_pkg, deq_if, assert_macros.svh
`include "assert_macros.svh"

module deq_front #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	deq_req_if.sink                 req,
	output logic                    cmd_push,
	output deq_pkg::deq_ctl_t       cmd_ctl,
	output logic [$clog2(DEPTH)-1:0] cmd_addr,
	output logic [DATA_WIDTH-1:0]   cmd_wdata,
	input  logic                    cmd_full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int IW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;

	logic [AW-1:0] head_q, head_n, head_dec, wrap_addr;
	logic [CW-1:0] count_q, count_n, offset;
	logic [SW-1:0] sum, wrapped;
	logic [IW-1:0] idx_w, cnt_w;
	logic          full, empty, idx_lt, idx_le;
	logic          we, re;
	logic [deq_pkg::STATUS_W-1:0] status;
	logic [AW-1:0] addr;

	assign req.ready = !cmd_full;
	assign cmd_push  = req.valid && req.ready;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign idx_w  = IW'(req.index);
	assign cnt_w  = IW'(count_q);
	assign idx_lt = (idx_w < cnt_w);
	assign idx_le = (idx_w <= cnt_w);

	// distance from the head for the one shared wrap adder
	always_comb begin
		unique case (req.mode)
			deq_pkg::MODE_PUSH_BACK: offset = count_q;
			deq_pkg::MODE_POP_BACK:  offset = count_q - 1'b1;
			deq_pkg::MODE_POP_FRONT: offset = CW'(1);
			default:                 offset = CW'(req.index);
		endcase
	end

	assign sum       = SW'(head_q) + SW'(offset);
	assign wrapped   = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
	assign wrap_addr = AW'(wrapped);
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		status  = deq_pkg::STATUS_OK;
		count_n = count_q;
		head_n  = head_q;
		addr    = wrap_addr;
		unique case (req.mode)
			deq_pkg::MODE_PUSH_BACK: begin
				if (full) status = deq_pkg::STATUS_FULL;
				else begin
					we      = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			deq_pkg::MODE_PUSH_FRONT: begin
				addr = head_dec;
				if (full) status = deq_pkg::STATUS_FULL;
				else begin
					we      = 1'b1;
					head_n  = head_dec;
					count_n = count_q + 1'b1;
				end
			end
			deq_pkg::MODE_POP_BACK: begin
				if (empty) status = deq_pkg::STATUS_RANGE;
				else begin
					re      = 1'b1;
					count_n = count_q - 1'b1;
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				addr = head_q;
				if (empty) status = deq_pkg::STATUS_RANGE;
				else begin
					re      = 1'b1;
					head_n  = wrap_addr;
					count_n = count_q - 1'b1;
				end
			end
			deq_pkg::MODE_READ_AT: begin
				if (!idx_lt) status = deq_pkg::STATUS_RANGE;
				else re = 1'b1;
			end
			deq_pkg::MODE_WRITE_AT: begin
				if (!idx_lt) status = deq_pkg::STATUS_RANGE;
				else we = 1'b1;
			end
			deq_pkg::MODE_DROP_FRONT: begin
				if (!idx_le) status = deq_pkg::STATUS_RANGE;
				else begin
					head_n  = wrap_addr;
					count_n = count_q - CW'(req.index);
				end
			end
			deq_pkg::MODE_DROP_BACK: begin
				if (!idx_le) status = deq_pkg::STATUS_RANGE;
				else count_n = count_q - CW'(req.index);
			end
			deq_pkg::MODE_CLEAR: begin
				head_n  = '0;
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	assign cmd_ctl.we        = we;
	assign cmd_ctl.re        = re;
	assign cmd_ctl.status    = status;
	assign cmd_ctl.occupancy = deq_pkg::OCC_W'(count_n);
	assign cmd_addr          = addr;
	assign cmd_wdata         = DATA_WIDTH'(req.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd_push) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
	`ASSERT_NEXT(a_clear_empties, cmd_push && req.mode == deq_pkg::MODE_CLEAR,
		count_q == '0 && head_q == '0, "clear did not empty the queue")

endmodule

/* rtl/deq_fifo.sv */
// two-entry command queue between front and back, first word visible at the output
// depends on assert_macros.svh
`include "assert_macros.svh"

module deq_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             nonempty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       fill_q;

	assign full     = (fill_q == 2'd2);
	assign nonempty = (fill_q != 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, push, !full || pop, "command queue overflow")
	`ASSERT_IMPLIES(a_no_underflow, pop, nonempty, "command queue underflow")
	`ASSERT_ALWAYS(a_fill_bound, fill_q <= 2'd2, "command queue fill out of range")

endmodule

/* rtl/deq_back.sv */
// back end: entry memory, read stage and output register
// depends on deq_pkg, deq_if, assert_macros.svh
`include "assert_macros.svh"

module deq_back #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  deq_pkg::deq_ctl_t        cmd_ctl,
	input  logic [$clog2(DEPTH)-1:0] cmd_addr,
	input  logic [DATA_WIDTH-1:0]    cmd_wdata,
	output logic                     cmd_pop,
	deq_rsp_if.source                rsp
);

	logic [DATA_WIDTH-1:0]        mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rdata_s1;
	deq_pkg::deq_ctl_t            ctl_s1;
	logic                         valid_s1;
	logic                         advance, free_s1;

	logic                                valid_q;
	logic signed [deq_pkg::DOUT_W-1:0]   data_out_q;
	logic [deq_pkg::OCC_W-1:0]           occupancy_q;
	logic [deq_pkg::STATUS_W-1:0]        status_q;

	assign advance = valid_s1 && (!valid_q || rsp.ready);
	assign free_s1 = !valid_s1 || advance;
	assign cmd_pop = cmd_valid && free_s1;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_ctl.we) mem[cmd_addr] <= cmd_wdata;
		if (cmd_pop && cmd_ctl.re) rdata_s1 <= mem[cmd_addr];
		if (cmd_pop) ctl_s1 <= cmd_ctl;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_out_q  <= ctl_s1.re ? deq_pkg::DOUT_W'(rdata_s1) : '0;
			occupancy_q <= ctl_s1.occupancy;
			status_q    <= ctl_s1.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (free_s1) valid_s1 <= cmd_pop;
			if (advance) valid_q <= 1'b1;
			else if (rsp.ready) valid_q <= 1'b0;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.data_out  = data_out_q;
	assign rsp.occupancy = occupancy_q;
	assign rsp.status    = status_q;

	// an access that fails its check never touches memory
	`ASSERT_IMPLIES(a_err_no_access, cmd_pop && cmd_ctl.status != deq_pkg::STATUS_OK,
		!cmd_ctl.we && !cmd_ctl.re, "failed request reached memory")
	`ASSERT_IMPLIES(a_err_zero_data, valid_q && status_q != deq_pkg::STATUS_OK,
		data_out_q == '0, "error transaction carries nonzero data")

endmodule
